[hw/rtl/can_blm_pkg.sv]
// Shared types, constants and the frame bit time function of the CAN bus load meter.
package can_blm_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_COUNT   = 2'd0;
    localparam logic [1:0] CMD_QUERY   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_RATE  = 2'd0;
    localparam logic [1:0] CFG_SECOND_RATE = 2'd1;
    localparam logic [1:0] CFG_CORE_CLOCK  = 2'd2;

    localparam int unsigned CLK_W   = 30;
    localparam int unsigned RATE_IW = 3;
    localparam logic [CLK_W-1:0] CORE_CLOCK_RESET = 30'd100000000;

    // Field widths
    localparam int unsigned ACC_W   = 32;
    localparam int unsigned TS_W    = 32;
    localparam int unsigned LOAD_W  = 7;
    localparam int unsigned FBITS_W = 8;
    localparam int unsigned IN_W    = 40;
    localparam int unsigned OUT_W   = 16;

    // Serial load datapath widths
    localparam int unsigned RATE_W    = 20;                 // up to 1000000
    localparam int unsigned PROD_W    = ACC_W + CLK_W;      // bits * clock
    localparam int unsigned DEN_W     = TS_W + RATE_W;      // rate * elapsed
    localparam int unsigned NUM_W     = PROD_W + 7;         // prod * 100
    localparam int unsigned DSH_W     = DEN_W + LOAD_W - 1; // den << 6
    localparam int unsigned STEP_W    = 5;

    localparam logic [STEP_W-1:0] MUL_STEPS   = 5'd30;
    localparam logic [STEP_W-1:0] SCALE_STEPS = 5'd7;
    localparam logic [STEP_W-1:0] DIV_STEPS   = 5'd7;

    localparam logic [RATE_W-1:0] RATE_BASE = 20'd125000;
    localparam logic [LOAD_W-1:0] LOAD_CAP  = 7'd100;

    // Frame bit time constants
    localparam logic [7:0]  STD_OVERHEAD   = 8'd47;
    localparam logic [7:0]  EXT_OVERHEAD   = 8'd67;
    localparam logic [3:0]  MAX_DATA_BYTES = 4'd8;
    localparam logic [10:0] STRETCH_NUM    = 11'd11;
    localparam logic [12:0] RECIP_TEN      = 13'd6554;  // 2^16 / 10, rounded up

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_PUT
    } top_state_t;

    typedef enum logic [2:0] {
        LD_IDLE,
        LD_MUL,
        LD_CMP,
        LD_SCALE,
        LD_DIV
    } ld_phase_t;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  bits;
        logic [TS_W-1:0]   elapsed;
        logic [1:0]        rate_sel;   // 0 = 125k ... 3 = 1M
    } ld_req_t;

    typedef struct packed {
        logic              done;
        logic [LOAD_W-1:0] load;
    } ld_resp_t;

    // (overhead + 8*len) * 11 / 10; divide by ten through a reciprocal,
    // exact for every product below 16384
    function automatic logic [FBITS_W-1:0] frame_bit_time(input logic ext,
                                                          input logic [3:0] len);
        logic [3:0]  len_c;
        logic [7:0]  base;
        logic [10:0] stretched;
        logic [23:0] scaled;
        len_c     = (len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : len;
        base      = (ext ? EXT_OVERHEAD : STD_OVERHEAD) + {1'b0, len_c, 3'b000};
        stretched = 11'({3'b000, base} * STRETCH_NUM);
        scaled    = 24'(stretched) * 24'(RECIP_TEN);
        return scaled[23:16];
    endfunction

endpackage

[hw/rtl/can_blm_load.sv]
// Bit-serial load unit: shift-add multiplies, scale by 100 and a restoring divide.
module can_blm_load
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  can_blm_pkg::ld_req_t               req,
    input  logic [can_blm_pkg::CLK_W-1:0]      clock_hz,
    output can_blm_pkg::ld_resp_t              resp
);

    can_blm_pkg::ld_phase_t phase_reg, phase_next;

    logic [can_blm_pkg::STEP_W-1:0]  step_reg,  step_next;
    logic [can_blm_pkg::NUM_W-1:0]   mcand_reg, mcand_next;
    logic [can_blm_pkg::CLK_W-1:0]   mplr_reg,  mplr_next;
    logic [can_blm_pkg::PROD_W-1:0]  prod_reg,  prod_next;
    logic [can_blm_pkg::DEN_W-1:0]   dcand_reg, dcand_next;
    logic [can_blm_pkg::RATE_W-1:0]  dplr_reg,  dplr_next;
    logic [can_blm_pkg::DEN_W-1:0]   den_reg,   den_next;
    logic [can_blm_pkg::NUM_W-1:0]   num_reg,   num_next;
    logic [can_blm_pkg::DSH_W-1:0]   dsh_reg,   dsh_next;
    logic [can_blm_pkg::LOAD_W-1:0]  quo_reg,   quo_next;
    logic                            done_reg,  done_next;
    logic                            fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= can_blm_pkg::LD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        prod_reg  <= prod_next;
        dcand_reg <= dcand_next;
        dplr_reg  <= dplr_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
    end

    assign fits = (num_reg >= can_blm_pkg::NUM_W'(dsh_reg));

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        prod_next  = prod_reg;
        dcand_next = dcand_reg;
        dplr_next  = dplr_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;

        case (phase_reg)
            can_blm_pkg::LD_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next = can_blm_pkg::NUM_W'(req.bits);
                    mplr_next  = clock_hz;
                    prod_next  = '0;
                    dcand_next = can_blm_pkg::DEN_W'(req.elapsed);
                    dplr_next  = can_blm_pkg::RATE_BASE << req.rate_sel;
                    den_next   = '0;
                    step_next  = can_blm_pkg::MUL_STEPS - 5'd1;
                    phase_next = can_blm_pkg::LD_MUL;
                end
            end
            can_blm_pkg::LD_MUL:
            begin
                // one multiplier bit of each product per cycle
                if (mplr_reg[0])
                    prod_next = prod_reg + mcand_reg[can_blm_pkg::PROD_W-1:0];
                if (dplr_reg[0])
                    den_next = den_reg + dcand_reg;
                mcand_next = mcand_reg << 1;
                mplr_next  = mplr_reg >> 1;
                dcand_next = dcand_reg << 1;
                dplr_next  = dplr_reg >> 1;
                step_next  = step_reg - 5'd1;
                if (step_reg == '0)
                    phase_next = can_blm_pkg::LD_CMP;
            end
            can_blm_pkg::LD_CMP:
            begin
                if (prod_reg >= can_blm_pkg::PROD_W'(den_reg))
                begin
                    // ratio of one or more: cap
                    quo_next   = can_blm_pkg::LOAD_CAP;
                    done_next  = 1'b1;
                    phase_next = can_blm_pkg::LD_IDLE;
                end
                else
                begin
                    mcand_next = can_blm_pkg::NUM_W'(prod_reg);
                    mplr_next  = can_blm_pkg::CLK_W'(can_blm_pkg::LOAD_CAP);
                    num_next   = '0;
                    dsh_next   = {den_reg, 6'b000000};
                    quo_next   = '0;
                    step_next  = can_blm_pkg::SCALE_STEPS - 5'd1;
                    phase_next = can_blm_pkg::LD_SCALE;
                end
            end
            can_blm_pkg::LD_SCALE:
            begin
                if (mplr_reg[0])
                    num_next = num_reg + mcand_reg;
                mcand_next = mcand_reg << 1;
                mplr_next  = mplr_reg >> 1;
                step_next  = step_reg - 5'd1;
                if (step_reg == '0)
                begin
                    step_next  = can_blm_pkg::DIV_STEPS - 5'd1;
                    phase_next = can_blm_pkg::LD_DIV;
                end
            end
            can_blm_pkg::LD_DIV:
            begin
                // one quotient bit per cycle, most significant first
                if (fits)
                    num_next = num_reg - can_blm_pkg::NUM_W'(dsh_reg);
                quo_next  = {quo_reg[can_blm_pkg::LOAD_W-2:0], fits};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                begin
                    done_next  = 1'b1;
                    phase_next = can_blm_pkg::LD_IDLE;
                end
            end
            default:
            begin
                phase_next = can_blm_pkg::LD_IDLE;
            end
        endcase
    end

    assign resp.done = done_reg;
    assign resp.load = quo_reg;

endmodule

[hw/rtl/can_bus_load_meter.sv]
// Top level of the two-channel CAN bus load meter: channel state, control and output stage.
//
//  Channel   Dir  Signals                            Contents (lowest bit first)
//  s_        in   s_tvalid s_tready s_tdata s_tuser  tdata: channel, data_length,
//                                                    extended_id, timestamp; tuser: command
//  m_        out  m_tvalid m_tready m_tdata          tdata: load_percent, frame_bits
//  cfg_      in   cfg_we cfg_index cfg_data          first rate 0, second rate 1, core clock 2
//
//  Count, restart and ignored items go from accept straight to the output stage. A query with
//  a rate set and a nonzero elapsed time first runs the load unit, which walks 30 multiplier
//  bits, one compare, 7 scale bits and 7 quotient bits one per cycle; a capped load stops
//  after the compare. One item is in flight at a time; the next item is taken while the last
//  result waits in the output register. Reset clears both channels, the rate indexes and sets
//  the clock to 100 MHz. A stalled output holds its item unchanged.
module can_bus_load_meter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [can_blm_pkg::IN_W-1:0]          s_tdata,  // channel[1:0] data_length[5:2]
                                                            // extended_id[6] timestamp[38:7]
    input  logic [1:0]                            s_tuser,  // command[1:0]
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [can_blm_pkg::OUT_W-1:0]         m_tdata,  // load_percent[6:0]
                                                            // frame_bits[14:7]
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [can_blm_pkg::CLK_W-1:0]         cfg_data
);

    // input field split
    logic [1:0]                     in_channel;
    logic [3:0]                     in_length;
    logic                           in_ext;
    logic [can_blm_pkg::TS_W-1:0]   in_ts;

    assign in_channel = s_tdata[1:0];
    assign in_length  = s_tdata[5:2];
    assign in_ext     = s_tdata[6];
    assign in_ts      = s_tdata[38:7];

    // configuration registers
    logic [can_blm_pkg::RATE_IW-1:0] rate1_reg;
    logic [can_blm_pkg::RATE_IW-1:0] rate2_reg;
    logic [can_blm_pkg::CLK_W-1:0]   clock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate1_reg <= '0;
            rate2_reg <= '0;
            clock_reg <= can_blm_pkg::CORE_CLOCK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                can_blm_pkg::CFG_FIRST_RATE:  rate1_reg <= cfg_data[can_blm_pkg::RATE_IW-1:0];
                can_blm_pkg::CFG_SECOND_RATE: rate2_reg <= cfg_data[can_blm_pkg::RATE_IW-1:0];
                can_blm_pkg::CFG_CORE_CLOCK:  clock_reg <= cfg_data;
                default:                      ; // no register there: drop the write
            endcase
        end
    end

    // per-channel state, entry 0 is channel one
    logic [can_blm_pkg::ACC_W-1:0] acc_reg [2];
    logic [can_blm_pkg::ACC_W-1:0] acc_next [2];
    logic [can_blm_pkg::TS_W-1:0]  ts_reg  [2];
    logic [can_blm_pkg::TS_W-1:0]  ts_next [2];

    can_blm_pkg::top_state_t          state_reg, state_next;
    logic [can_blm_pkg::LOAD_W-1:0]   res_load_reg, res_load_next;
    logic [can_blm_pkg::FBITS_W-1:0]  res_bits_reg, res_bits_next;
    logic                             out_valid_reg, out_valid_next;
    logic [can_blm_pkg::OUT_W-1:0]    out_data_reg, out_data_next;

    can_blm_pkg::ld_req_t   ld_req;
    can_blm_pkg::ld_resp_t  ld_resp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= can_blm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg[0]    <= '0;
            acc_reg[1]    <= '0;
            ts_reg[0]     <= '0;
            ts_reg[1]     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            ts_reg        <= ts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_load_reg <= res_load_next;
        res_bits_reg <= res_bits_next;
        out_data_reg <= out_data_next;
    end

    // item decode
    logic                               ch_ok;
    logic                               k;
    logic [can_blm_pkg::RATE_IW-1:0]    rate_idx;
    logic                               rate_on;
    logic [can_blm_pkg::FBITS_W-1:0]    fbits;
    logic [can_blm_pkg::ACC_W:0]        acc_sum;
    logic [can_blm_pkg::TS_W-1:0]       elapsed;

    assign ch_ok    = (in_channel == 2'd1) || (in_channel == 2'd2);
    assign k        = in_channel[1];
    assign rate_idx = k ? rate2_reg : rate1_reg;
    assign rate_on  = (rate_idx >= 3'd1) && (rate_idx <= 3'd4);
    assign fbits    = can_blm_pkg::frame_bit_time(in_ext, in_length);
    assign acc_sum  = {1'b0, acc_reg[k]} + (can_blm_pkg::ACC_W + 1)'(fbits);
    assign elapsed  = in_ts - ts_reg[k];

    always_comb
    begin
        state_next      = state_reg;
        res_load_next   = res_load_reg;
        res_bits_next   = res_bits_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        acc_next        = acc_reg;
        ts_next         = ts_reg;
        s_tready        = 1'b0;
        ld_req.start    = 1'b0;
        ld_req.bits     = acc_reg[k];
        ld_req.elapsed  = elapsed;
        ld_req.rate_sel = 2'(rate_idx - 3'd1);

        // drain the output register
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            can_blm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    res_load_next = '0;
                    res_bits_next = '0;
                    state_next    = can_blm_pkg::ST_PUT;
                    if (ch_ok)
                    begin
                        case (s_tuser)
                            can_blm_pkg::CMD_COUNT:
                            begin
                                // saturate instead of wrapping
                                res_bits_next = fbits;
                                acc_next[k]   = acc_sum[can_blm_pkg::ACC_W] ?
                                                '1 : acc_sum[can_blm_pkg::ACC_W-1:0];
                            end
                            can_blm_pkg::CMD_QUERY:
                            begin
                                if (rate_on)
                                begin
                                    acc_next[k] = '0;
                                    ts_next[k]  = in_ts;
                                    // zero elapsed reports zero without the divide
                                    if (elapsed != '0)
                                    begin
                                        ld_req.start = 1'b1;
                                        state_next   = can_blm_pkg::ST_CALC;
                                    end
                                end
                            end
                            can_blm_pkg::CMD_RESTART:
                            begin
                                acc_next[k] = '0;
                                ts_next[k]  = in_ts;
                            end
                            default:
                            begin
                                // unknown command: change nothing
                            end
                        endcase
                    end
                end
            end
            can_blm_pkg::ST_CALC:
            begin
                if (ld_resp.done)
                begin
                    res_load_next = ld_resp.load;
                    state_next    = can_blm_pkg::ST_PUT;
                end
            end
            can_blm_pkg::ST_PUT:
            begin
                // advance once the output register is free or being taken
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_bits_reg, res_load_reg};
                    state_next     = can_blm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = can_blm_pkg::ST_IDLE;
            end
        endcase
    end

    can_blm_load u_load
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ld_req),
        .clock_hz (clock_reg),
        .resp     (ld_resp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[hw/rtl/can_blm_checker.sv]
// Port-level checks of the CAN bus load meter and their binding to the top level.
module can_blm_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [can_blm_pkg::OUT_W-1:0]  m_tdata
);

    logic [can_blm_pkg::LOAD_W-1:0]  chk_load;
    logic [can_blm_pkg::FBITS_W-1:0] chk_bits;

    assign chk_load = m_tdata[6:0];
    assign chk_bits = m_tdata[14:7];

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // load never exceeds the cap
    a_load_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> chk_load <= can_blm_pkg::LOAD_CAP)
        else $error("load above cap");

    // a result carries a load or a frame bit time, never both
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (chk_load == '0) || (chk_bits == '0))
        else $error("load and frame bits both set");

    // frame bit time lies between the shortest and the longest frame
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15] == 1'b0
                     && (chk_bits == '0 || (chk_bits >= 8'd51 && chk_bits <= 8'd144)))
        else $error("frame bit time out of range");

    // ready drops after an item is accepted with the output idle
    a_fast_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |-> ##1 !s_tready)
        else $error("ready held while an item is in flight");

endmodule

bind can_bus_load_meter can_blm_checker u_can_blm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/can_bus_load_meter_test.sv]
// Self-checking testbench for the two-channel CAN bus load meter.
`timescale 1ns / 100ps

module can_bus_load_meter_test;

    // Command and channel codes not covered by the package
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [1:0] CH_NONE     = 2'd0;
    localparam logic [1:0] CH_FIRST    = 2'd1;
    localparam logic [1:0] CH_SECOND   = 2'd2;
    localparam logic [1:0] CH_SPARE    = 2'd3;

    // Rate index coding; 5..7 carry no rate and turn the channel off
    localparam logic [2:0] RATE_OFF       = 3'd0;
    localparam logic [2:0] RATE_125K      = 3'd1;
    localparam logic [2:0] RATE_250K      = 3'd2;
    localparam logic [2:0] RATE_500K      = 3'd3;
    localparam logic [2:0] RATE_1M        = 3'd4;
    localparam logic [2:0] RATE_SPARE_LO  = 3'd5;
    localparam logic [2:0] RATE_SPARE_MID = 3'd6;
    localparam logic [2:0] RATE_SPARE_HI  = 3'd7;

    // Frame bit time terms
    localparam int unsigned HDR_BITS_STD = 47;
    localparam int unsigned HDR_BITS_EXT = 67;
    localparam int unsigned PAYLOAD_MAX  = 8;
    localparam int unsigned FULL_LOAD    = 100;

    localparam int unsigned N_PHASES     = 8;
    localparam int unsigned PHASE_ITEMS  = 205;
    localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int unsigned SETTLE_CYCLES = 64;   // outlasts one full query

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  channel;
        logic [3:0]  data_length;
        logic        extended_id;
        logic [31:0] timestamp;
    } bus_item_t;

    typedef struct packed {
        logic [can_blm_pkg::LOAD_W-1:0]  load_percent;
        logic [can_blm_pkg::FBITS_W-1:0] frame_bits;
    } meter_reading_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [can_blm_pkg::IN_W-1:0]     s_tdata;   // channel[1:0] data_length[5:2]
                                                 // extended_id[6] timestamp[38:7]
    logic [1:0]                       s_tuser;   // command[1:0]
    logic                             m_tvalid;
    logic                             m_tready;
    logic [can_blm_pkg::OUT_W-1:0]    m_tdata;   // load_percent[6:0] frame_bits[14:7]
    logic                             cfg_we;
    logic [1:0]                       cfg_index;
    logic [can_blm_pkg::CLK_W-1:0]    cfg_data;

    // Per-phase settings: sender idle and receiver stall in percent, rates, clock
    int unsigned      ph_idle[N_PHASES]  = '{0, 63, 0, 19, 0, 63, 0, 19};
    int unsigned      ph_stall[N_PHASES] = '{0, 0, 63, 19, 0, 0, 63, 19};
    logic [2:0]       ph_first[N_PHASES] = '{RATE_1M, RATE_125K, RATE_250K, RATE_500K,
                                             RATE_OFF, RATE_SPARE_MID, RATE_1M, RATE_125K};
    logic [2:0]       ph_second[N_PHASES] = '{RATE_125K, RATE_1M, RATE_500K, RATE_250K,
                                              RATE_SPARE_LO, RATE_SPARE_HI, RATE_1M,
                                              RATE_250K};
    logic [can_blm_pkg::CLK_W-1:0] ph_clock[N_PHASES] = '{30'd100000000, 30'd1,
                                                          30'd1000000000, 30'h3FFFFFFF,
                                                          30'd24000000, 30'd80000000,
                                                          30'd0, 30'd16000000};

    // Commands waiting for the driver and readings waiting for the block
    bus_item_t      cmd_backlog[$];
    meter_reading_t readings_due[$];

    int unsigned items_queued;
    int unsigned items_taken;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;
    logic        feed_taken;

    // Predictor copy of the meter: configuration and per-channel state
    logic [2:0]                    rate_sel_first;
    logic [2:0]                    rate_sel_second;
    logic [can_blm_pkg::CLK_W-1:0] tick_hz;
    logic [31:0]                   chan_bits[2];
    logic [31:0]                   chan_mark[2];

    can_bus_load_meter i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Bit time of one classic frame, stretched by a tenth for stuff bits
    function automatic int unsigned bit_time_of(input logic [3:0] len, input logic ext);
        int unsigned bytes;
        int unsigned hdr;
        bytes = (len > PAYLOAD_MAX) ? PAYLOAD_MAX : len;
        hdr   = ext ? HDR_BITS_EXT : HDR_BITS_STD;
        return (hdr + 8 * bytes) * 11 / 10;
    endfunction

    function automatic logic [31:0] rate_hz(input logic [2:0] sel);
        case (sel)
            RATE_125K: return 32'd125000;
            RATE_250K: return 32'd250000;
            RATE_500K: return 32'd500000;
            RATE_1M:   return 32'd1000000;
            default:   return 32'd0;
        endcase
    endfunction

    // bits*clock*100 / (rate*elapsed), truncated, capped at full load
    function automatic logic [can_blm_pkg::LOAD_W-1:0] load_of(input logic [31:0] bits,
                                                               input logic [31:0] rate,
                                                               input logic [31:0] elapsed);
        logic [63:0] prod;
        logic [63:0] den;
        prod = 64'(bits) * 64'(tick_hz);
        den  = 64'(rate) * 64'(elapsed);
        if (den == 64'd0)
            return '0;
        // prod*100/den reaches 100 exactly when prod reaches den
        if (prod >= den)
            return can_blm_pkg::LOAD_W'(FULL_LOAD);
        return can_blm_pkg::LOAD_W'((prod * 64'd100) / den);
    endfunction

    // Apply one accepted command to the predictor and return the reading it yields
    task automatic meter_account(input bus_item_t it, output meter_reading_t rd);
        int unsigned  k;
        logic [32:0]  sum;
        logic [2:0]   sel;
        logic [31:0]  elapsed;
        logic [31:0]  bits;
        rd = '0;
        if (it.channel == CH_FIRST || it.channel == CH_SECOND)
        begin
            k = (it.channel == CH_FIRST) ? 0 : 1;
            case (it.command)
                can_blm_pkg::CMD_COUNT:
                begin
                    rd.frame_bits = can_blm_pkg::FBITS_W'(
                                        bit_time_of(it.data_length, it.extended_id));
                    sum = 33'(chan_bits[k]) + 33'(rd.frame_bits);
                    // saturate instead of wrapping
                    chan_bits[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                can_blm_pkg::CMD_QUERY:
                begin
                    sel = (k == 0) ? rate_sel_first : rate_sel_second;
                    if (rate_hz(sel) != 32'd0)
                    begin
                        elapsed      = it.timestamp - chan_mark[k];
                        bits         = chan_bits[k];
                        chan_mark[k] = it.timestamp;
                        chan_bits[k] = '0;
                        if (elapsed != 32'd0)
                            rd.load_percent = load_of(bits, rate_hz(sel), elapsed);
                    end
                end
                can_blm_pkg::CMD_RESTART:
                begin
                    chan_bits[k] = '0;
                    chan_mark[k] = it.timestamp;
                end
                default: ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic push_item(input logic [1:0] cmd, input logic [1:0] ch,
                             input logic [3:0] len, input logic ext,
                             input logic [31:0] ts);
        bus_item_t it;
        it.command     = cmd;
        it.channel     = ch;
        it.data_length = len;
        it.extended_id = ext;
        it.timestamp   = ts;
        cmd_backlog.push_back(it);
        items_queued++;
    endtask

    // Write one register; only called while the block has nothing in flight
    task automatic write_reg(input logic [1:0] idx,
                             input logic [can_blm_pkg::CLK_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            can_blm_pkg::CFG_FIRST_RATE:  rate_sel_first  = val[2:0];
            can_blm_pkg::CFG_SECOND_RATE: rate_sel_second = val[2:0];
            can_blm_pkg::CFG_CORE_CLOCK:  tick_hz         = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued command was taken and every reading came back
    task automatic drain();
        while (items_taken != items_queued || readings_due.size() != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed measurement windows: restart, a burst of frames, then a
    // query placed so that the load lands anywhere from idle to beyond saturation.
    // The rest is noise over the full range of every field.
    task automatic run_phase(input int unsigned quota);
        int unsigned  first_item;
        logic [1:0]   ch;
        logic [31:0]  mark;
        logic [31:0]  rate;
        int unsigned  bits;
        int unsigned  n_frames;
        int unsigned  target;
        logic [3:0]   len;
        logic         ext;
        logic [63:0]  span;
        first_item = items_queued;
        while (items_queued - first_item < quota)
        begin
            if ($urandom_range(99) < 75)
            begin
                ch   = $urandom_range(1) ? CH_SECOND : CH_FIRST;
                mark = $urandom();
                bits = 0;
                // now and then skip the restart to leave a stale window open
                if ($urandom_range(9) != 0)
                    push_item(can_blm_pkg::CMD_RESTART, ch, 4'($urandom_range(15)),
                              1'($urandom_range(1)), mark);
                n_frames = $urandom_range(12);
                repeat (n_frames)
                begin
                    len  = 4'($urandom_range(15));
                    ext  = 1'($urandom_range(1));
                    bits += bit_time_of(len, ext);
                    push_item(can_blm_pkg::CMD_COUNT, ch, len, ext, $urandom());
                end
                rate = rate_hz((ch == CH_FIRST) ? rate_sel_first : rate_sel_second);
                case ($urandom_range(9))
                    0:       span = 64'd0;
                    1:       span = 64'($urandom());
                    default:
                    begin
                        if (rate == 32'd0)
                            span = 64'($urandom_range(1, 100000));
                        else
                        begin
                            target = $urandom_range(1, 130);
                            span = (64'(bits) * 64'(tick_hz) * 64'd100) /
                                   (64'(rate) * 64'(target));
                            if (span == 64'd0)
                                span = 64'd1;
                            if (span > 64'hFFFF_FFFF)
                                span = 64'hFFFF_FFFF;
                        end
                    end
                endcase
                push_item(can_blm_pkg::CMD_QUERY, ch, 4'($urandom_range(15)),
                          1'($urandom_range(1)), mark + span[31:0]);
            end
            else
            begin
                push_item(2'($urandom_range(3)), 2'($urandom_range(3)),
                          4'($urandom_range(15)), 1'($urandom_range(1)), $urandom());
            end
        end
    endtask

    // Driver: present the next command at the falling edge once the last one was taken
    always @(negedge clk)
    begin : feed
        bus_item_t nxt;
        if (rst_n)
        begin
            if (!s_tvalid || feed_taken)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, nxt.timestamp, nxt.extended_id, nxt.data_length,
                                 nxt.channel};
                    s_tuser  <= nxt.command;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on every accepted command, check every accepted reading
    always @(posedge clk)
    begin : watch
        bus_item_t      got_item;
        meter_reading_t want;
        meter_reading_t seen;
        if (rst_n)
        begin
            feed_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                got_item.command     = s_tuser;
                got_item.channel     = s_tdata[1:0];
                got_item.data_length = s_tdata[5:2];
                got_item.extended_id = s_tdata[6];
                got_item.timestamp   = s_tdata[38:7];
                meter_account(got_item, want);
                readings_due.push_back(want);
                items_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                seen.load_percent = m_tdata[6:0];
                seen.frame_bits   = m_tdata[14:7];
                if (readings_due.size() == 0)
                begin
                    report_mismatch("unexpected reading, load_percent", seen.load_percent, 0);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (seen.load_percent != want.load_percent)
                        report_mismatch("load_percent", seen.load_percent, want.load_percent);
                    if (seen.frame_bits != want.frame_bits)
                        report_mismatch("frame_bits", seen.frame_bits, want.frame_bits);
                end
            end
            // Watchdog: advance while neither side moves, end the run at the limit
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("can_bus_load_meter_test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        feed_taken      = 1'b0;
        items_queued    = 0;
        items_taken     = 0;
        quiet_cycles    = 0;
        errors          = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        // predictor starts from the reset state of the block
        rate_sel_first  = RATE_OFF;
        rate_sel_second = RATE_OFF;
        tick_hz         = can_blm_pkg::CORE_CLOCK_RESET;
        chan_bits       = '{default: '0};
        chan_mark       = '{default: '0};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: frame sizes, ignored items, load cap, zero elapsed, counter wrap
        write_reg(can_blm_pkg::CFG_FIRST_RATE, can_blm_pkg::CLK_W'(RATE_1M));
        write_reg(can_blm_pkg::CFG_SECOND_RATE, can_blm_pkg::CLK_W'(RATE_125K));
        write_reg(can_blm_pkg::CFG_CORE_CLOCK, 30'd100000000);
        push_item(can_blm_pkg::CMD_COUNT, CH_FIRST, 4'd0, 1'b0, 32'd0);
        push_item(can_blm_pkg::CMD_COUNT, CH_FIRST, 4'd8, 1'b1, 32'hA5A5_5A5A);
        // long length code
        push_item(can_blm_pkg::CMD_COUNT, CH_FIRST, 4'd15, 1'b0, 32'hFFFF_FFFF);
        push_item(can_blm_pkg::CMD_COUNT, CH_SECOND, 4'd9, 1'b1, 32'd0);
        // invalid channels and an unknown command
        push_item(can_blm_pkg::CMD_COUNT, CH_NONE, 4'd8, 1'b1, 32'd0);
        push_item(can_blm_pkg::CMD_RESTART, CH_SPARE, 4'd0, 1'b0, 32'h1234);
        push_item(CMD_UNKNOWN, CH_FIRST, 4'd4, 1'b1, 32'h55);
        // far beyond full load, then zero elapsed
        push_item(can_blm_pkg::CMD_QUERY, CH_FIRST, 4'd0, 1'b0, 32'd10);
        push_item(can_blm_pkg::CMD_QUERY, CH_FIRST, 4'd0, 1'b0, 32'd10);
        push_item(can_blm_pkg::CMD_RESTART, CH_FIRST, 4'd0, 1'b0, 32'hFFFF_FF00);
        push_item(can_blm_pkg::CMD_COUNT, CH_FIRST, 4'd4, 1'b0, 32'd0);
        // counter wraps
        push_item(can_blm_pkg::CMD_QUERY, CH_FIRST, 4'd0, 1'b0, 32'h0000_1000);
        push_item(can_blm_pkg::CMD_RESTART, CH_SECOND, 4'd0, 1'b0, 32'd0);
        push_item(can_blm_pkg::CMD_COUNT, CH_SECOND, 4'd8, 1'b0, 32'd0);
        // half load
        push_item(can_blm_pkg::CMD_QUERY, CH_SECOND, 4'd0, 1'b0, 32'd195200);
        push_item(can_blm_pkg::CMD_QUERY, CH_NONE, 4'd0, 1'b0, 32'd77);
        drain();

        // Directed: channel off, idle-channel count and restart, zero clock
        write_reg(can_blm_pkg::CFG_FIRST_RATE, can_blm_pkg::CLK_W'(RATE_OFF));
        write_reg(can_blm_pkg::CFG_SECOND_RATE, can_blm_pkg::CLK_W'(RATE_500K));
        write_reg(can_blm_pkg::CFG_CORE_CLOCK, 30'd0);
        push_item(can_blm_pkg::CMD_COUNT, CH_FIRST, 4'd3, 1'b1, 32'd0);
        push_item(can_blm_pkg::CMD_RESTART, CH_FIRST, 4'd0, 1'b0, 32'd5);
        push_item(can_blm_pkg::CMD_QUERY, CH_FIRST, 4'd0, 1'b0, 32'd100);
        push_item(can_blm_pkg::CMD_COUNT, CH_SECOND, 4'd2, 1'b1, 32'd0);
        push_item(can_blm_pkg::CMD_QUERY, CH_SECOND, 4'd0, 1'b0, 32'd1000);
        drain();

        // Random phases, each under its own settings and handshake pressure
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_reg(can_blm_pkg::CFG_FIRST_RATE, can_blm_pkg::CLK_W'(ph_first[p]));
            write_reg(can_blm_pkg::CFG_SECOND_RATE, can_blm_pkg::CLK_W'(ph_second[p]));
            write_reg(can_blm_pkg::CFG_CORE_CLOCK, ph_clock[p]);
            sender_idle_pct = ph_idle[p];
            recv_stall_pct  = ph_stall[p];
            run_phase(PHASE_ITEMS);
            drain();
        end

        // Let any stray reading show up before deciding
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("can_bus_load_meter_test passed");
        else
            $display("can_bus_load_meter_test failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/can_blm_pkg.sv
hw/rtl/can_blm_load.sv
hw/rtl/can_bus_load_meter.sv
hw/rtl/can_blm_checker.sv
sim/can_bus_load_meter_test.sv
